>>> sv/mrf_pkg.sv
package mrf_pkg;

    // ring sizes
    localparam int DUP_DEPTH  = 8;
    localparam int PATH_DEPTH = 8;
    localparam int DUP_AW     = (DUP_DEPTH > 1) ? $clog2(DUP_DEPTH) : 1;
    localparam int PATH_AW    = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int SCAN_AW    = (DUP_AW > PATH_AW) ? DUP_AW : PATH_AW;

    // entry layouts: dup {seq, host}, path {retries, hops, host}
    localparam int HOST_W = 32;
    localparam int BYTE_W = 8;
    localparam int DUP_W  = HOST_W + BYTE_W;
    localparam int PATH_W = HOST_W + 2 * BYTE_W;

    // stream widths
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 32;

    // dispositions
    localparam logic [1:0] DISP_DROP   = 2'd0;
    localparam logic [1:0] DISP_RECV   = 2'd1;
    localparam logic [1:0] DISP_XMIT   = 2'd2;
    localparam logic [1:0] DISP_URGENT = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_LEVEL = 2'd0;
    localparam logic [1:0] CFG_SLACK = 2'd1;
    localparam logic [1:0] CFG_MAXH  = 2'd2;
    localparam logic [1:0] CFG_OWN   = 2'd3;

endpackage

>>> sv/mrf_ram.sv
module mrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> sv/mesh_route_filter.sv
// Items pass IDLE, then RX or TX; one settled at the first checks, or a transmit without
// lookup, goes straight to DONE, a receive without a ring search goes on through LRN and
// DEC, and each ring search adds SCAN and POST: a receive may search the duplicate ring
// and then the path ring twice. One item is in work at a time; the next is taken once
// the block is back in IDLE after the result loads, later under stalls.
// Reset (synchronous, active low) restores config and control state and clears both rings via valid bits.
module mesh_route_filter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // is_empty, is_proxy, is_master_msg, is_trace, sender, receiver, seq_in,
    // hops_in, cap_in, urgent, cap_extra
    input  logic [mrf_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // func
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // make_copy, hops_out, cap_out, seq_out
    output logic [mrf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // disposition
    output logic [1:0]   m_axis_tuser
);

    localparam int DA = mrf_pkg::DUP_AW;
    localparam int PA = mrf_pkg::PATH_AW;
    localparam int SA = mrf_pkg::SCAN_AW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RX   = 4'd1;
    localparam logic [3:0] S_LRN  = 4'd2;
    localparam logic [3:0] S_DEC  = 4'd3;
    localparam logic [3:0] S_TX   = 4'd4;
    localparam logic [3:0] S_SCAN = 4'd5;
    localparam logic [3:0] S_POST = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    localparam logic [1:0] PH_DUP = 2'd0;
    localparam logic [1:0] PH_LRN = 2'd1;
    localparam logic [1:0] PH_BUD = 2'd2;
    localparam logic [1:0] PH_TX  = 2'd3;

    // configuration
    logic [1:0]  r_level;
    logic [7:0]  r_slack;
    logic [7:0]  r_maxh;
    logic [31:0] r_own;

    // block state
    logic [3:0]  r_state;
    logic [DA-1:0] r_dhead;
    logic [PA-1:0] r_phead;
    logic [mrf_pkg::DUP_DEPTH-1:0]  r_dvld;
    logic [mrf_pkg::PATH_DEPTH-1:0] r_pvld;
    logic [31:0] r_mid;
    logic [7:0]  r_mseq, r_mhops, r_mret, r_sseq;

    // latched item
    logic        r_empty, r_proxy, r_mmsg, r_trace, r_urgent;
    logic [31:0] r_snd, r_rcv;
    logic [7:0]  r_seq, r_hops, r_cap;
    logic [3:0]  r_extra;

    // pending result
    logic [1:0]  r_p_disp;
    logic        r_p_copy;
    logic [7:0]  r_p_hops, r_p_cap, r_p_seq;

    // output register
    logic        r_ovalid;
    logic [1:0]  r_o_disp;
    logic        r_o_copy;
    logic [7:0]  r_o_hops, r_o_cap, r_o_seq;

    // search engine
    logic          r_ring;
    logic [1:0]    r_phase;
    logic [31:0]   r_key;
    logic [SA-1:0] r_addr, r_left, r_paddr;
    logic          r_pend, r_pbit, r_found;
    logic [SA-1:0] r_kidx;
    logic [mrf_pkg::PATH_W-1:0] r_kdata;

    logic [mrf_pkg::DUP_W-1:0]  dup_rd, dup_wd;
    logic [mrf_pkg::PATH_W-1:0] path_rd, path_wd;
    logic          dup_we, path_we;
    logic [DA-1:0] dup_wa;
    logic [PA-1:0] path_wa;

    mrf_ram #(.WIDTH(mrf_pkg::DUP_W), .DEPTH(mrf_pkg::DUP_DEPTH)) u_dup_ram (
        .i_clk  (i_clk),
        .i_we   (dup_we),
        .i_waddr(dup_wa),
        .i_wdata(dup_wd),
        .i_raddr(r_addr[DA-1:0]),
        .o_rdata(dup_rd)
    );

    mrf_ram #(.WIDTH(mrf_pkg::PATH_W), .DEPTH(mrf_pkg::PATH_DEPTH)) u_path_ram (
        .i_clk  (i_clk),
        .i_we   (path_we),
        .i_waddr(path_wa),
        .i_wdata(path_wd),
        .i_raddr(r_addr[PA-1:0]),
        .o_rdata(path_rd)
    );

    // read data of the entry checked this cycle, zero where never written
    logic [mrf_pkg::PATH_W-1:0] scan_data;
    logic                       scan_hit;
    always_comb begin
        if (!r_pbit) begin
            scan_data = '0;
        end else if (r_ring) begin
            scan_data = path_rd;
        end else begin
            scan_data = {8'd0, dup_rd};
        end
        scan_hit = r_pend && !r_found && (scan_data[31:0] == r_key);
    end

    logic [SA-1:0] addr_prev;
    always_comb begin
        if (r_ring) begin
            addr_prev = (r_addr == '0) ? SA'(mrf_pkg::PATH_DEPTH - 1) : r_addr - 1'b1;
        end else begin
            addr_prev = (r_addr == '0) ? SA'(mrf_pkg::DUP_DEPTH - 1) : r_addr - 1'b1;
        end
    end

    logic [DA-1:0] dhead_prev, dhead_next;
    logic [PA-1:0] phead_prev, phead_next;
    assign dhead_prev = (r_dhead == '0) ? DA'(mrf_pkg::DUP_DEPTH - 1) : r_dhead - 1'b1;
    assign dhead_next = (r_dhead == DA'(mrf_pkg::DUP_DEPTH - 1)) ? '0 : r_dhead + 1'b1;
    assign phead_prev = (r_phead == '0) ? PA'(mrf_pkg::PATH_DEPTH - 1) : r_phead - 1'b1;
    assign phead_next = (r_phead == PA'(mrf_pkg::PATH_DEPTH - 1)) ? '0 : r_phead + 1'b1;

    // hop budget: cap - hops - distance + retries + slack, sign bit marks a fail
    logic [7:0]  b_cap, b_dist, b_ret;
    logic [10:0] b_sum;
    logic        b_fail;
    always_comb begin
        b_cap  = (r_cap == 8'd0) ? r_maxh : r_cap;
        b_dist = (r_state == S_DEC) ? r_mhops : r_kdata[39:32];
        b_ret  = (r_state == S_DEC) ? r_mret : r_kdata[47:40];
        b_sum  = {3'd0, b_cap} - {3'd0, r_hops} - {3'd0, b_dist}
               + {3'd0, b_ret} + {3'd0, r_slack};
        b_fail = b_sum[10];
    end

    // transmit cap from a learned distance, saturating
    logic [7:0] tx_dist;
    logic [8:0] tx_sum;
    logic [7:0] tx_cap;
    always_comb begin
        tx_dist = (r_state == S_TX) ? r_mhops : r_kdata[39:32];
        tx_sum  = {1'b0, tx_dist} + {5'd0, r_extra};
        tx_cap  = tx_sum[8] ? 8'hFF : tx_sum[7:0];
    end

    logic [7:0] kret_inc, mret_inc;
    assign kret_inc = (r_kdata[47:40] == 8'hFF) ? 8'hFF : r_kdata[47:40] + 8'd1;
    assign mret_inc = (r_mret == 8'hFF) ? 8'hFF : r_mret + 8'd1;

    logic dup_repeat;
    assign dup_repeat = r_found && (r_kdata[39:32] == r_seq);

    logic lrn_direct;
    assign lrn_direct = (r_state == S_LRN) && r_level[1] && (r_snd != r_mid)
                      && (r_snd == 32'd0);

    // ring write-back
    always_comb begin
        dup_we  = (r_state == S_POST) && (r_phase == PH_DUP) && !dup_repeat;
        dup_wa  = r_found ? r_kidx[DA-1:0] : r_dhead;
        dup_wd  = {r_seq, r_snd};
        path_we = 1'b0;
        path_wa = r_phead;
        path_wd = {8'd0, r_hops, r_snd};
        if (lrn_direct) begin
            path_we = 1'b1;
        end else if (r_state == S_POST && r_phase == PH_LRN) begin
            path_we = 1'b1;
            if (r_found) begin
                path_wa = r_kidx[PA-1:0];
            end
        end else if (r_state == S_POST && r_phase == PH_BUD && r_found && b_fail) begin
            path_we = 1'b1;
            path_wa = r_kidx[PA-1:0];
            path_wd = {kret_inc, r_kdata[39:0]};
        end
    end

    logic in_acc;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= 2'd2;
            r_slack  <= 8'd0;
            r_maxh   <= 8'd15;
            r_own    <= 32'd1;
            r_state  <= S_IDLE;
            r_dhead  <= '0;
            r_phead  <= '0;
            r_dvld   <= '0;
            r_pvld   <= '0;
            r_mid    <= '0;
            r_mseq   <= '0;
            r_mhops  <= '0;
            r_mret   <= '0;
            r_sseq   <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mrf_pkg::CFG_LEVEL: r_level <= i_cfg_wdata[1:0];
                    mrf_pkg::CFG_SLACK: r_slack <= i_cfg_wdata[7:0];
                    mrf_pkg::CFG_MAXH:  r_maxh  <= i_cfg_wdata[7:0];
                    mrf_pkg::CFG_OWN:   r_own   <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // output register: load a finished item, else empty on accept
            if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            // ring bookkeeping follows the writes
            if (dup_we && !r_found) begin
                r_dvld[r_dhead] <= 1'b1;
                r_dhead         <= dhead_next;
            end
            if (path_we && (lrn_direct || !r_found)) begin
                r_pvld[r_phead] <= 1'b1;
                r_phead         <= phead_next;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_empty  <= s_axis_tdata[0];
                        r_proxy  <= s_axis_tdata[1];
                        r_mmsg   <= s_axis_tdata[2];
                        r_trace  <= s_axis_tdata[3];
                        r_snd    <= s_axis_tdata[35:4];
                        r_rcv    <= s_axis_tdata[67:36];
                        r_seq    <= s_axis_tdata[75:68];
                        r_hops   <= (s_axis_tdata[83:76] == 8'hFF) ? 8'hFF
                                  : s_axis_tdata[83:76] + 8'd1;
                        r_cap    <= s_axis_tdata[91:84];
                        r_urgent <= s_axis_tdata[92];
                        r_extra  <= s_axis_tdata[96:93];
                        r_p_copy <= 1'b0;
                        if (s_axis_tuser) begin
                            r_sseq   <= r_sseq + 8'd1;
                            r_p_seq  <= r_sseq + 8'd1;
                            r_p_hops <= 8'd0;
                            r_p_cap  <= 8'd0;
                            r_p_disp <= s_axis_tdata[92] ? mrf_pkg::DISP_URGENT
                                                         : mrf_pkg::DISP_XMIT;
                            r_state  <= S_TX;
                        end else begin
                            r_p_seq  <= s_axis_tdata[75:68];
                            r_p_hops <= (s_axis_tdata[83:76] == 8'hFF) ? 8'hFF
                                      : s_axis_tdata[83:76] + 8'd1;
                            r_p_cap  <= s_axis_tdata[91:84];
                            r_p_disp <= mrf_pkg::DISP_DROP;
                            r_state  <= S_RX;
                        end
                    end
                end

                // drop checks and freshness against the master entry
                S_RX: begin
                    if (r_empty) begin
                        r_state <= S_DONE;
                    end else if (r_proxy) begin
                        if (r_rcv == 32'd0 || r_rcv == r_own) begin
                            r_p_disp <= mrf_pkg::DISP_RECV;
                        end
                        r_state <= S_DONE;
                    end else if (r_snd == r_own) begin
                        r_state <= S_DONE;
                    end else if (r_level == 2'd0) begin
                        r_state <= S_LRN;
                    end else if (r_snd == r_mid) begin
                        if (r_mseq == r_seq) begin
                            r_state <= S_DONE;
                        end else begin
                            r_mseq  <= r_seq;
                            r_state <= S_LRN;
                        end
                    end else if (r_mmsg && (r_rcv == 32'd0 || r_rcv == r_own)) begin
                        r_mid   <= r_snd;
                        r_mseq  <= r_seq;
                        r_mhops <= r_hops;
                        r_mret  <= 8'd0;
                        r_state <= S_LRN;
                    end else begin
                        r_ring  <= 1'b0;
                        r_phase <= PH_DUP;
                        r_key   <= r_snd;
                        r_addr  <= SA'(dhead_prev);
                        r_left  <= SA'(mrf_pkg::DUP_DEPTH - 1);
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end

                // path learning for the sender
                S_LRN: begin
                    if (!r_level[1]) begin
                        r_state <= S_DEC;
                    end else if (r_snd == r_mid) begin
                        r_mhops <= r_hops;
                        r_mret  <= 8'd0;
                        r_state <= S_DEC;
                    end else if (r_snd == 32'd0) begin
                        r_state <= S_DEC;
                    end else begin
                        r_ring  <= 1'b1;
                        r_phase <= PH_LRN;
                        r_key   <= r_snd;
                        r_addr  <= SA'(phead_prev);
                        r_left  <= SA'(mrf_pkg::PATH_DEPTH - 1);
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end

                // receive / forward decision
                S_DEC: begin
                    r_state <= S_DONE;
                    if (r_rcv == r_own) begin
                        r_p_disp <= mrf_pkg::DISP_RECV;
                    end else if (r_rcv == 32'd0) begin
                        r_p_disp <= mrf_pkg::DISP_RECV;
                        r_p_copy <= 1'b1;
                    end else if (r_hops >= r_maxh) begin
                        r_p_disp <= mrf_pkg::DISP_DROP;
                    end else if (!r_level[1] || (r_rcv == r_mid && !b_fail)) begin
                        r_p_disp <= r_trace ? mrf_pkg::DISP_DROP : mrf_pkg::DISP_XMIT;
                        r_p_copy <= r_trace;
                    end else if (r_rcv == r_mid) begin
                        r_mret <= mret_inc;
                    end else begin
                        r_ring  <= 1'b1;
                        r_phase <= PH_BUD;
                        r_key   <= r_rcv;
                        r_addr  <= SA'(phead_prev);
                        r_left  <= SA'(mrf_pkg::PATH_DEPTH - 1);
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end

                // transmit cap lookup
                S_TX: begin
                    if (!r_level[1] || r_proxy || r_rcv == 32'd0) begin
                        r_state <= S_DONE;
                    end else if (r_rcv == r_mid) begin
                        r_p_cap <= tx_cap;
                        r_state <= S_DONE;
                    end else begin
                        r_ring  <= 1'b1;
                        r_phase <= PH_TX;
                        r_key   <= r_rcv;
                        r_addr  <= SA'(phead_prev);
                        r_left  <= SA'(mrf_pkg::PATH_DEPTH - 1);
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end

                // ring search: one read issued and one entry compared a cycle
                S_SCAN: begin
                    if (r_left != '0) begin
                        r_addr  <= addr_prev;
                        r_left  <= r_left - 1'b1;
                        r_pend  <= 1'b1;
                        r_paddr <= r_addr;
                        r_pbit  <= r_ring ? r_pvld[r_addr[PA-1:0]] : r_dvld[r_addr[DA-1:0]];
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_POST;
                        end
                    end
                    if (scan_hit) begin
                        r_found <= 1'b1;
                        r_kidx  <= r_paddr;
                        r_kdata <= scan_data;
                    end
                end

                // act on the search result
                S_POST: begin
                    case (r_phase)
                        PH_DUP: r_state <= dup_repeat ? S_DONE : S_LRN;
                        PH_LRN: r_state <= S_DEC;
                        PH_BUD: begin
                            if (!r_found || !b_fail) begin
                                r_p_disp <= r_trace ? mrf_pkg::DISP_DROP
                                                    : mrf_pkg::DISP_XMIT;
                                r_p_copy <= r_trace;
                            end
                            r_state <= S_DONE;
                        end
                        default: begin
                            if (r_found) begin
                                r_p_cap <= tx_cap;
                            end
                            r_state <= S_DONE;
                        end
                    endcase
                end

                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_o_disp <= r_p_disp;
                        r_o_copy <= r_p_copy;
                        r_o_hops <= r_p_hops;
                        r_o_cap  <= r_p_cap;
                        r_o_seq  <= r_p_seq;
                        r_state  <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_disp;
    assign m_axis_tdata  = {7'd0, r_o_seq, r_o_cap, r_o_hops, r_o_copy};

endmodule

>>> sv/mrf_checker.sv
module mrf_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a waiting result is not withdrawn
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one item in work: input closes right after an accept
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

    // zero hop count only comes from a transmit item
    a_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8:1] == 8'd0 |->
        (m_axis_tuser == mrf_pkg::DISP_XMIT || m_axis_tuser == mrf_pkg::DISP_URGENT)
        && !m_axis_tdata[0])
        else $error("bad transmit result");

    // copies go with drop or receive only
    a_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
        (m_axis_tuser == mrf_pkg::DISP_DROP || m_axis_tuser == mrf_pkg::DISP_RECV))
        else $error("copy with forward disposition");

endmodule

bind mesh_route_filter mrf_checker u_mrf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
